// ===== hw/rtl/gf3d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gf3d_pkg;
    localparam int DataWidth = 32;
    localparam int FracBits  = 16;
    localparam int IoWidth   = 32;
    localparam int InTdataW  = 9 * IoWidth;
    localparam int OutTdataW = 9 * IoWidth;

    // shared unit operations
    typedef enum logic [1:0] {
        t_OP_MUL = 2'd0,
        t_OP_ADD = 2'd1,
        t_OP_SUB = 2'd2,
        t_OP_DIV = 2'd3
    } t_op;
endpackage
`default_nettype wire

// ===== hw/rtl/gf3d_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gf3d_alu import gf3d_pkg::*; #(
    parameter int DATA_WIDTH = DataWidth,
    parameter int FRAC_BITS  = FracBits
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire t_op                          i_op,
    input  wire logic signed [DATA_WIDTH-1:0] i_a,
    input  wire logic signed [DATA_WIDTH-1:0] i_b,
    output logic                              o_done,
    output logic signed [DATA_WIDTH-1:0]      o_res
);
    localparam int DW = DATA_WIDTH;
    localparam int NW = DW + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam logic [DW:0] MAXM = {2'b00, {(DW-1){1'b1}}};
    localparam logic [DW:0] MINM = {2'b01, {(DW-1){1'b0}}};

    logic [NW-1:0]   r_num;
    logic [DW-1:0]   r_den;
    logic [DW:0]     r_rem;
    logic [NW-1:0]   r_quo;
    logic [CW-1:0]   r_cnt;
    logic            r_neg;
    logic            r_busy;
    logic            r_done;
    logic signed [DW-1:0] r_res;

    logic [DW-1:0]   mag_a;
    logic [DW-1:0]   mag_b;
    logic [2*DW-1:0] prod;
    logic [2*DW-1:0] prod_sh;
    logic signed [DW:0] sum;
    logic [DW:0]     rem_sh;
    logic            ge;
    logic            neg;

    function automatic logic signed [DW-1:0] sat_mag(input logic [2*DW-1:0] m,
                                                     input logic n);
        logic [2*DW-1:0] lim;
        logic [2*DW-1:0] v;
        begin
            lim = n ? {{(DW-1){1'b0}}, MINM} : {{(DW-1){1'b0}}, MAXM};
            v = (m > lim) ? lim : m;
            sat_mag = n ? DW'(-v) : DW'(v);
        end
    endfunction

    assign mag_a = i_a[DW-1] ? DW'(-i_a) : DW'(i_a);
    assign mag_b = i_b[DW-1] ? DW'(-i_b) : DW'(i_b);
    assign neg   = i_a[DW-1] ^ i_b[DW-1];
    assign prod  = mag_a * mag_b;
    assign prod_sh = prod >> FRAC_BITS;
    assign sum   = (i_op == t_OP_SUB) ? ($signed({i_a[DW-1], i_a}) - $signed({i_b[DW-1], i_b}))
                                      : ($signed({i_a[DW-1], i_a}) + $signed({i_b[DW-1], i_b}));
    assign rem_sh = {r_rem[DW-1:0], r_num[NW-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                unique case (i_op)
                    t_OP_MUL: begin
                        r_res  <= sat_mag(prod_sh, neg);
                        r_done <= 1'b1;
                    end
                    t_OP_ADD, t_OP_SUB: begin
                        if (sum > $signed(MAXM)) r_res <= MAXM[DW-1:0];
                        else if (sum < -$signed(MINM)) r_res <= MINM[DW-1:0];
                        else r_res <= sum[DW-1:0];
                        r_done <= 1'b1;
                    end
                    t_OP_DIV: begin
                        r_num  <= {mag_a, {FRAC_BITS{1'b0}}};
                        r_den  <= mag_b;
                        r_rem  <= '0;
                        r_quo  <= '0;
                        r_neg  <= neg;
                        r_cnt  <= CW'(NW);
                        r_busy <= 1'b1;
                    end
                    default: ;
                endcase
            end else if (r_busy) begin
                // restoring division, one quotient bit a cycle
                r_rem <= ge ? rem_sh - {1'b0, r_den} : rem_sh;
                r_quo <= {r_quo[NW-2:0], ge};
                r_num <= r_num << 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= sat_mag({{(DW-FRAC_BITS){1'b0}}, r_quo[NW-2:0], ge}, r_neg);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule
`default_nettype wire

// ===== hw/rtl/gaussian_fusion_3d_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Information-form fusion of two 3-D Gaussian estimates.
// Input stream: tdata holds mean x,y,z then cov xx,xy,xz,yy,yz,zz (Q16.16),
// tuser holds pair_end. A word with pair_end low is inverted and stored as
// the first estimate; no output word results. A word with pair_end high is
// inverted, added to the stored estimate, the sum inverted back, and one
// output word with the fused mean and covariance is sent; tuser is the
// singular flag, and all values are zero when it is set.
// Every multiply, add and divide goes through one shared unit under a
// microcode sequencer, and a divide step waits for every quotient bit. On a
// zero determinant the six divides of an inversion are skipped. A first word
// keeps tready low until its inversion and matrix times vector are done; a
// second word keeps it low until its output word is in the output register,
// so a new word is taken only when the unit is through with the last one.
// The output word is held in a register until taken; a new input word is
// accepted while it waits, and the result of that word waits for the slot.
// Reset clears the sequencer and the stored singular flag; the stored
// estimate is undefined until a first word is accepted.
module gaussian_fusion_3d_unit import gf3d_pkg::*; #(
    parameter int DATA_WIDTH = DataWidth,
    parameter int FRAC_BITS  = FracBits
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // mean_x, mean_y, mean_z, cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz
    input  wire logic [InTdataW-1:0]  s_axis_tdata,
    // pair_end
    input  wire logic                 s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // fused_mean_x,y,z, fused_cov_xx, xy, xz, yy, yz, zz
    output logic [OutTdataW-1:0]      m_axis_tdata,
    // singular
    output logic                      m_axis_tuser
);
    localparam int DW = DATA_WIDTH;
    // register file slots
    localparam int RM = 0;   // mean / eta sum, 3
    localparam int RC = 3;   // matrix to invert, 6
    localparam int RY = RC;  // inverse, written over the matrix after det
    localparam int RK = 9;   // cofactors, 6
    localparam int RE = 15;  // eta, 3
    localparam int RT = 18;  // temps, 3
    localparam int R1 = 21;  // stored Y1, 6
    localparam int RV = 27;  // stored eta1, 3
    localparam int NR = 30;
    localparam int AW = $clog2(NR);

    typedef enum logic [2:0] {
        S_IDLE, S_ISSUE, S_WAIT, S_DET, S_NEXT, S_OUT
    } t_state;

    typedef struct packed {
        t_op           op;
        logic [AW-1:0] a;
        logic [AW-1:0] b;
        logic [AW-1:0] d;
    } t_uop;

    // microcode: inversion of RC into RY (cofactors, det, divides)
    localparam int NINV = 27;
    localparam int NMV  = 15;

    function automatic t_uop uop(input t_op o, input int a, input int b, input int d);
        uop.op = o;
        uop.a = AW'(a);
        uop.b = AW'(b);
        uop.d = AW'(d);
    endfunction

    // inversion steps, k=0..22 before divides; det in RT+2
    function automatic t_uop inv_step(input logic [4:0] k);
        localparam int A = RC, B = RC+1, C = RC+2, D = RC+3, E = RC+4, F = RC+5;
        t_uop u;
        begin
            u = uop(t_OP_MUL, A, A, RT);
            unique case (k)
                5'd0:  u = uop(t_OP_MUL, D, F, RT);
                5'd1:  u = uop(t_OP_MUL, E, E, RT+1);
                5'd2:  u = uop(t_OP_SUB, RT, RT+1, RK);
                5'd3:  u = uop(t_OP_MUL, C, E, RT);
                5'd4:  u = uop(t_OP_MUL, B, F, RT+1);
                5'd5:  u = uop(t_OP_SUB, RT, RT+1, RK+1);
                5'd6:  u = uop(t_OP_MUL, B, E, RT);
                5'd7:  u = uop(t_OP_MUL, C, D, RT+1);
                5'd8:  u = uop(t_OP_SUB, RT, RT+1, RK+2);
                5'd9:  u = uop(t_OP_MUL, A, F, RT);
                5'd10: u = uop(t_OP_MUL, C, C, RT+1);
                5'd11: u = uop(t_OP_SUB, RT, RT+1, RK+3);
                5'd12: u = uop(t_OP_MUL, B, C, RT);
                5'd13: u = uop(t_OP_MUL, A, E, RT+1);
                5'd14: u = uop(t_OP_SUB, RT, RT+1, RK+4);
                5'd15: u = uop(t_OP_MUL, A, D, RT);
                5'd16: u = uop(t_OP_MUL, B, B, RT+1);
                5'd17: u = uop(t_OP_SUB, RT, RT+1, RK+5);
                5'd18: u = uop(t_OP_MUL, A, RK, RT+2);
                5'd19: u = uop(t_OP_MUL, B, RK+1, RT);
                5'd20: u = uop(t_OP_ADD, RT+2, RT, RT+2);
                5'd21: u = uop(t_OP_MUL, C, RK+2, RT);
                5'd22: u = uop(t_OP_ADD, RT+2, RT, RT+2);
                5'd23: u = uop(t_OP_DIV, RK, RT+2, RY);
                5'd24: u = uop(t_OP_DIV, RK+1, RT+2, RY+1);
                5'd25: u = uop(t_OP_DIV, RK+2, RT+2, RY+2);
                5'd26: u = uop(t_OP_DIV, RK+3, RT+2, RY+3);
                5'd27: u = uop(t_OP_DIV, RK+4, RT+2, RY+4);
                5'd28: u = uop(t_OP_DIV, RK+5, RT+2, RY+5);
                default: ;
            endcase
            inv_step = u;
        end
    endfunction

    // matrix (RY) times vector (RM) into RE
    function automatic t_uop mv_step(input logic [3:0] k);
        int row, col, mi;
        t_uop u;
        begin
            row = (k < 4'd5) ? 0 : (k < 4'd10) ? 1 : 2;
            col = int'(k) - 5 * row;
            u = uop(t_OP_MUL, RY, RM, RT);
            if (col < 3) begin
                mi = (row == 0) ? col : (row == 1) ? ((col == 0) ? 1 : col + 2)
                   : ((col == 0) ? 2 : (col == 1) ? 4 : 5);
                u = uop(t_OP_MUL, RY + mi, RM + col, (col == 0) ? RE + row : RT);
            end else begin
                u = uop(t_OP_ADD, RE + row, RT, RE + row);
            end
            // order: m0,m1,add,m2,add per row
            if (col == 2) u = uop(t_OP_ADD, RE + row, RT, RE + row);
            if (col == 3) u = uop(t_OP_MUL, RY + ((row == 0) ? 2 : (row == 1) ? 4 : 5), RM + 2, RT);
            mv_step = u;
        end
    endfunction

    localparam int NINVS = 29;

    // phases: 0 invert input, 1 mv eta, 2 sum, 3 invert sum, 4 mv mean
    t_state r_state;
    logic [2:0] r_phase;
    logic [4:0] r_step;
    logic       r_pend;
    logic       r_sing;
    logic       r_sing1;
    logic       r_ovalid;
    logic [OutTdataW-1:0] r_odata;
    logic       r_osing;
    logic signed [DW-1:0] r_reg [NR];

    t_uop cur;
    logic start;
    logic signed [DW-1:0] alu_a, alu_b, alu_res;
    logic alu_done;

    function automatic logic signed [DW-1:0] load32(input logic [IoWidth-1:0] x);
        logic signed [DW+IoWidth-1:0] v;
        begin
            v = (DW+IoWidth)'($signed(x));
            if (v > (DW+IoWidth)'((64'sd1 <<< (DW-1)) - 1))
                load32 = {1'b0, {(DW-1){1'b1}}};
            else if (v < -(DW+IoWidth)'(64'sd1 <<< (DW-1)))
                load32 = {1'b1, {(DW-1){1'b0}}};
            else load32 = v[DW-1:0];
        end
    endfunction

    function automatic logic [IoWidth-1:0] store32(input logic signed [DW-1:0] v);
        logic signed [DW+IoWidth-1:0] w;
        begin
            w = (DW+IoWidth)'(v);
            if (w > (DW+IoWidth)'(2147483647)) store32 = 32'h7fff_ffff;
            else if (w < -(DW+IoWidth)'(64'sd2147483648)) store32 = 32'h8000_0000;
            else store32 = w[IoWidth-1:0];
        end
    endfunction

    always_comb begin
        cur = uop(t_OP_ADD, 0, 0, 0);
        unique case (r_phase)
            3'd0, 3'd3: cur = inv_step(r_step);
            3'd1, 3'd4: cur = mv_step(r_step[3:0]);
            default: begin
                if (r_step < 5'd6) cur = uop(t_OP_ADD, R1 + int'(r_step), RY + int'(r_step),
                                             RC + int'(r_step));
                else cur = uop(t_OP_ADD, RV + int'(r_step) - 6, RE + int'(r_step) - 6,
                               RM + int'(r_step) - 6);
            end
        endcase
    end

    assign start = (r_state == S_ISSUE);
    assign alu_a = r_reg[cur.a];
    assign alu_b = r_reg[cur.b];

    gf3d_alu #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (cur.op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    logic [4:0] last_step;
    always_comb begin
        unique case (r_phase)
            3'd0, 3'd3: last_step = 5'(NINVS - 1);
            3'd1, 3'd4: last_step = 5'(NMV - 1);
            default:    last_step = 5'd8;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_osing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sing1  <= 1'b0;
            r_ovalid <= 1'b0;
            r_phase  <= '0;
            r_step   <= '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready && r_state != S_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        for (int i = 0; i < 3; i++)
                            r_reg[RM+i] <= load32(s_axis_tdata[i*IoWidth +: IoWidth]);
                        for (int i = 0; i < 6; i++)
                            r_reg[RC+i] <= load32(s_axis_tdata[(i+3)*IoWidth +: IoWidth]);
                        r_pend  <= s_axis_tuser;
                        r_sing  <= 1'b0;
                        r_phase <= 3'd0;
                        r_step  <= '0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: r_state <= S_WAIT;
                S_WAIT: begin
                    if (alu_done) begin
                        r_reg[cur.d] <= alu_res;
                        r_state <= ((r_phase == 3'd0 || r_phase == 3'd3) && r_step == 5'd22)
                                   ? S_DET : S_NEXT;
                    end
                end
                S_DET: begin
                    // zero determinant: inverse is zero, skip the divides
                    if (r_reg[RT+2] == '0) begin
                        r_sing <= 1'b1;
                        for (int i = 0; i < 6; i++) r_reg[RY+i] <= '0;
                        r_step <= last_step;
                    end
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_step != last_step) begin
                        r_step  <= r_step + 1'b1;
                        r_state <= S_ISSUE;
                    end else begin
                        r_step <= '0;
                        r_state <= S_ISSUE;
                        unique case (r_phase)
                            3'd0: r_phase <= 3'd1;
                            3'd1: begin
                                if (!r_pend) begin
                                    for (int i = 0; i < 6; i++) r_reg[R1+i] <= r_reg[RY+i];
                                    for (int i = 0; i < 3; i++) r_reg[RV+i] <= r_reg[RE+i];
                                    r_sing1 <= r_sing;
                                    r_state <= S_IDLE;
                                end else r_phase <= 3'd2;
                            end
                            3'd2: r_phase <= 3'd3;
                            3'd3: r_phase <= 3'd4;
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        for (int i = 0; i < 3; i++)
                            r_odata[i*IoWidth +: IoWidth] <=
                                (r_sing || r_sing1) ? '0 : store32(r_reg[RE+i]);
                        for (int i = 0; i < 6; i++)
                            r_odata[(i+3)*IoWidth +: IoWidth] <=
                                (r_sing || r_sing1) ? '0 : store32(r_reg[RY+i]);
                        r_osing  <= r_sing || r_sing1;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== tb/tb_gaussian_fusion_3d_unit.sv =====
`timescale 1ns / 1ps
module tb_gaussian_fusion_3d_unit;
    import gf3d_pkg::*;

    localparam longint MaxV = (64'sd1 <<< (DataWidth - 1)) - 1;
    localparam longint MinV = -MaxV - 1;
    localparam int WatchLimit = 30000;
    localparam logic [31:0] One = 32'h0001_0000;

    typedef struct packed {
        logic                 pe;
        logic [InTdataW-1:0]  data;
        logic                 typed;
        logic [OutTdataW-1:0] exp_data;
        logic                 exp_sing;
    } t_stim_row;

    typedef struct packed {
        logic [OutTdataW-1:0] data;
        logic                 sing;
    } t_fused;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // mean_x, mean_y, mean_z, cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz
    logic [InTdataW-1:0]  s_axis_tdata = '0;
    // pair_end
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // fused_mean_x,y,z, fused_cov_xx, xy, xz, yy, yz, zz
    logic [OutTdataW-1:0] m_axis_tdata;
    // singular
    logic                 m_axis_tuser;

    gaussian_fusion_3d_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // stored first estimate, mirrored
    longint   y1 [6];
    longint   eta1 [3];
    bit       y1_sing;
    bit       have_first;
    t_fused   fused_q [$];
    int       tx_idle, rx_idle;
    int       n_errors, n_words_in, n_fused, n_singular, stall_cnt;
    bit       timed_out;

    function automatic longint clamp(longint v);
        if (v > MaxV) return MaxV;
        if (v < MinV) return MinV;
        return v;
    endfunction

    function automatic longint sat_mag(longint unsigned m, bit ng);
        if (ng) return (m > longint'(MaxV) + 1) ? MinV : -longint'(m);
        return (m > longint'(MaxV)) ? MaxV : longint'(m);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        longint unsigned ma, mb;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        return sat_mag((ma * mb) >> FracBits, (a < 0) != (b < 0));
    endfunction

    function automatic longint fx_div(longint a, longint b);
        longint unsigned ma, mb;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        return sat_mag((ma << FracBits) / mb, (a < 0) != (b < 0));
    endfunction

    function automatic longint sum3(longint p, longint q, longint r);
        return clamp(clamp(p + q) + r);
    endfunction

    // adjugate inverse of a symmetric 3x3 in xx, xy, xz, yy, yz, zz order
    function automatic bit invert_sym(input longint m [6], output longint r [6]);
        longint cof [6];
        longint det;
        cof[0] = clamp(fx_mul(m[3], m[5]) - fx_mul(m[4], m[4]));
        cof[1] = clamp(fx_mul(m[2], m[4]) - fx_mul(m[1], m[5]));
        cof[2] = clamp(fx_mul(m[1], m[4]) - fx_mul(m[2], m[3]));
        cof[3] = clamp(fx_mul(m[0], m[5]) - fx_mul(m[2], m[2]));
        cof[4] = clamp(fx_mul(m[1], m[2]) - fx_mul(m[0], m[4]));
        cof[5] = clamp(fx_mul(m[0], m[3]) - fx_mul(m[1], m[1]));
        det = sum3(fx_mul(m[0], cof[0]), fx_mul(m[1], cof[1]), fx_mul(m[2], cof[2]));
        for (int k = 0; k < 6; k++) r[k] = (det == 0) ? 0 : fx_div(cof[k], det);
        return det == 0;
    endfunction

    function automatic void sym_times_vec(input longint m [6], input longint v [3],
                                          output longint o [3]);
        o[0] = sum3(fx_mul(m[0], v[0]), fx_mul(m[1], v[1]), fx_mul(m[2], v[2]));
        o[1] = sum3(fx_mul(m[1], v[0]), fx_mul(m[3], v[1]), fx_mul(m[4], v[2]));
        o[2] = sum3(fx_mul(m[2], v[0]), fx_mul(m[4], v[1]), fx_mul(m[5], v[2]));
    endfunction

    // returns 1 and the fused word when the input word is a pair end
    function automatic bit fuse_estimate(input logic pe, input logic [InTdataW-1:0] d,
                                         output t_fused res);
        longint mean [3];
        longint cov [6];
        longint y [6];
        longint eta [3];
        longint ysum [6];
        longint esum [3];
        longint fcov [6];
        longint fmean [3];
        bit     sing;
        for (int k = 0; k < 3; k++) mean[k] = clamp(longint'($signed(d[k*32 +: 32])));
        for (int k = 0; k < 6; k++) cov[k] = clamp(longint'($signed(d[(k+3)*32 +: 32])));
        sing = invert_sym(cov, y);
        sym_times_vec(y, mean, eta);
        res = '0;
        if (!pe) begin
            y1 = y;
            eta1 = eta;
            y1_sing = sing;
            return 0;
        end
        for (int k = 0; k < 6; k++) ysum[k] = clamp(y1[k] + y[k]);
        for (int k = 0; k < 3; k++) esum[k] = clamp(eta1[k] + eta[k]);
        if (invert_sym(ysum, fcov)) sing = 1;
        if (y1_sing) sing = 1;
        sym_times_vec(fcov, esum, fmean);
        res.sing = sing;
        if (!sing) begin
            for (int k = 0; k < 3; k++) res.data[k*32 +: 32] = fmean[k][31:0];
            for (int k = 0; k < 6; k++) res.data[(k+3)*32 +: 32] = fcov[k][31:0];
        end
        return 1;
    endfunction

    function automatic logic [InTdataW-1:0] pack_est(
        logic [31:0] mx, logic [31:0] my, logic [31:0] mz, logic [31:0] xx,
        logic [31:0] xy, logic [31:0] xz, logic [31:0] yy, logic [31:0] yz,
        logic [31:0] zz);
        return {zz, yz, yy, xz, xy, xx, mz, my, mx};
    endfunction

    function automatic logic [31:0] rand_small(int unsigned span);
        return $urandom_range(2 * span) - span;
    endfunction

    // roughly well conditioned covariance with random content
    function automatic logic [InTdataW-1:0] rand_estimate();
        logic [31:0] dx, dy, dz, mx, my, mz;
        dx = $urandom_range(32'h0008_0000, 32'h0000_4000);
        dy = $urandom_range(32'h0008_0000, 32'h0000_4000);
        dz = $urandom_range(32'h0008_0000, 32'h0000_4000);
        if ($urandom_range(9) == 0) begin
            mx = $urandom; my = $urandom; mz = $urandom;
        end else begin
            mx = rand_small(32'h0040_0000);
            my = rand_small(32'h0040_0000);
            mz = rand_small(32'h0040_0000);
        end
        return pack_est(mx, my, mz, dx, rand_small(32'h1000), rand_small(32'h1000),
                        dy, rand_small(32'h1000), dz);
    endfunction

    task automatic send_word(logic pe, logic [InTdataW-1:0] d, output t_fused res,
                             output bit has_res);
        while ($urandom_range(99) < tx_idle) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = d;
        s_axis_tuser = pe;
        do @(posedge i_clk); while (!s_axis_tready);
        has_res = fuse_estimate(pe, d, res);
        if (!pe) have_first = 1;
        n_words_in++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_checked(logic pe, logic [InTdataW-1:0] d);
        t_fused r;
        bit     h;
        send_word(pe, d, r, h);
        if (h) fused_q = {fused_q, r};
    endtask

    // output side
    always @(negedge i_clk) m_axis_tready = ($urandom_range(99) >= rx_idle);

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cnt = 0;
            else
                stall_cnt++;
            if (m_axis_tvalid && m_axis_tready) begin
                if (fused_q.size() == 0) begin
                    $display("%0t: unexpected word %h sing %b", $time, m_axis_tdata,
                             m_axis_tuser);
                    n_errors++;
                end else begin
                    t_fused e;
                    e = fused_q.pop_front();
                    n_fused++;
                    if (e.sing) n_singular++;
                    for (int k = 0; k < 9; k++)
                        if (m_axis_tdata[k*32 +: 32] !== e.data[k*32 +: 32]) begin
                            $display("%0t: field %0d expected %h actual %h", $time, k,
                                     e.data[k*32 +: 32], m_axis_tdata[k*32 +: 32]);
                            n_errors++;
                        end
                    if (m_axis_tuser !== e.sing) begin
                        $display("%0t: singular expected %b actual %b", $time, e.sing,
                                 m_axis_tuser);
                        n_errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_cnt >= WatchLimit && !timed_out) begin
            timed_out = 1;
            $display("%0t: timeout, %0d words still expected", $time, fused_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    t_stim_row dir_tbl [$];

    function automatic void add_row(logic pe, logic [InTdataW-1:0] d, logic typed,
                                    logic [OutTdataW-1:0] e, logic es);
        t_stim_row r;
        r.pe = pe; r.data = d; r.typed = typed; r.exp_data = e; r.exp_sing = es;
        dir_tbl = {dir_tbl, r};
    endfunction

    initial begin
        logic [InTdataW-1:0] ident, half_fused, mx_all, mn_all, est;
        t_fused r;
        bit     h;
        int     total, pick;
        n_errors = 0; n_words_in = 0; n_fused = 0; n_singular = 0; stall_cnt = 0;
        timed_out = 0; have_first = 0; y1_sing = 0;
        for (int k = 0; k < 6; k++) y1[k] = 0;
        for (int k = 0; k < 3; k++) eta1[k] = 0;
        tx_idle = 26; rx_idle = 58;
        ident = pack_est(0, 0, 0, One, 0, 0, One, 0, One);
        half_fused = pack_est(32'h8000, 32'h10000, 32'h18000, 32'h8000, 0, 0, 32'h8000,
                              0, 32'h8000);
        mx_all = {9{32'h7fff_ffff}};
        mn_all = {9{32'h8000_0000}};

        add_row(0, pack_est(One, 2 * One, 3 * One, One, 0, 0, One, 0, One), 0, '0, 0);
        add_row(1, ident, 1, half_fused, 0);
        add_row(1, ident, 1, half_fused, 0);  // second again, same stored estimate
        add_row(1, '0, 1, '0, 1);              // singular second
        add_row(0, '0, 0, '0, 0);              // singular first
        add_row(1, ident, 1, '0, 1);
        add_row(0, mx_all, 0, '0, 0);
        add_row(1, mn_all, 0, '0, 0);
        add_row(0, mn_all, 0, '0, 0);
        add_row(1, mx_all, 0, '0, 0);
        add_row(0, pack_est(32'h7fff_ffff, 32'h8000_0000, 0, 32'h7fff_ffff, 0, 0,
                            32'h7fff_ffff, 0, 32'h7fff_ffff), 0, '0, 0);
        add_row(1, pack_est(32'h8000_0000, 32'h7fff_ffff, 1, 1, 0, 0, 1, 0, 1), 0, '0, 0);
        add_row(0, rand_estimate(), 0, '0, 0);
        add_row(1, rand_estimate(), 0, '0, 0);

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tbl[i]) begin
            send_word(dir_tbl[i].pe, dir_tbl[i].data, r, h);
            if (h) begin
                if (dir_tbl[i].typed) begin
                    r.data = dir_tbl[i].exp_data;
                    r.sing = dir_tbl[i].exp_sing;
                end
                fused_q = {fused_q, r};
            end
        end

        total = 1050;
        while (n_words_in < total) begin
            if (n_words_in > total / 3 && tx_idle == 26) begin
                tx_idle = 58; rx_idle = 26;
            end else if (n_words_in > 2 * total / 3 && tx_idle == 58) begin
                tx_idle = 0; rx_idle = 0;
            end
            if (n_words_in > 400 && n_words_in < 404) begin
                // drain fully before the next word
                while (fused_q.size() != 0) @(negedge i_clk);
            end
            pick = $urandom_range(99);
            if (pick < 72) begin
                send_checked(0, rand_estimate());
                send_checked(1, rand_estimate());
            end else if (pick < 82) begin
                send_checked(1, rand_estimate());
            end else if (pick < 92) begin
                est = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom};
                send_checked($urandom_range(1), est);
            end else begin
                // well formed pair with one field forced to an extreme
                est = rand_estimate();
                est[$urandom_range(8)*32 +: 32] = $urandom_range(1) ? 32'h7fff_ffff
                                                                     : 32'h8000_0000;
                send_checked(0, est);
                send_checked(1, rand_estimate());
            end
        end

        while (fused_q.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);

        $display("sent %0d estimates, checked %0d fused words (%0d singular)",
                 n_words_in, n_fused, n_singular);
        $display("covered extremes, singular inputs, repeated pair ends, random noise");
        if (n_errors == 0 && fused_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
